// ===== rtl/priority_voice_channel_allocator_core_assert.svh =====
// Assertion macros of the channel allocator controller RTL.
`ifndef PRIORITY_VOICE_CHANNEL_ALLOCATOR_CORE_ASSERT_SVH
`define PRIORITY_VOICE_CHANNEL_ALLOCATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, clocked on clk and disabled during reset.
`define PVCA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, clocked on clk and disabled during reset.
`define PVCA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PVCA_ASSERT_IMP(lbl, ante, cons, msg)
`define PVCA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/pvca_pkg.sv =====
// Shared types and constants of the voice channel allocator.
`timescale 1ns / 1ps
`default_nettype none

package pvca_pkg;

    // Fixed field widths of the item ports.
    localparam int SOUND_W     = 8;
    localparam int PRI_W       = 8;
    localparam int IN_ORIGIN_W = 16;
    localparam int CHAN_W      = 3;
    localparam int CFG_CNT_W   = 4;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    // Register indexes, taken from paddr[2].
    localparam logic [0:0] REG_IDX_CHANNELS = 1'd0;
    localparam logic [0:0] REG_IDX_ENABLE   = 1'd1;

    // Request codes.
    typedef enum logic [1:0] {
        FUNC_START   = 2'd0,
        FUNC_STOP    = 2'd1,
        FUNC_RELEASE = 2'd2,
        FUNC_CLEAR   = 2'd3
    } func_t;

    // Result codes.
    typedef enum logic [1:0] {
        KIND_GRANTED = 2'd0,
        KIND_STOPPED = 2'd1,
        KIND_REFUSED = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    // One result item travelling from the controller to the output register.
    typedef struct packed {
        kind_t              kind;
        logic [CHAN_W-1:0]  channel;
        logic               last;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/pvca_chan_mem.sv =====
// Channel table memory: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module pvca_chan_mem #(
    parameter int DEPTH   = 8,
    parameter int ADDR_W  = 3,
    parameter int DATA_W  = 33
) (
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem_array [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/pvca_out_reg.sv =====
// Output register that holds one result item until the receiver takes it.
`timescale 1ns / 1ps
`default_nettype none

module pvca_out_reg (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            res_push,
    input  wire pvca_pkg::res_t  res,
    output logic                 res_ready,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output logic [1:0]           event_kind,
    output logic [2:0]           channel,
    output logic                 last
);
    import pvca_pkg::*;

    logic valid_reg;
    logic valid_next;
    res_t data_reg;
    res_t data_next;

    // The register takes a new item when empty or when it drains this cycle.
    assign res_ready = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (res_push)
        begin
            valid_next = 1'b1;
            data_next  = res;
        end
        else if (valid_reg && !out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid  = valid_reg;
    assign event_kind = data_reg.kind;
    assign channel    = data_reg.channel;
    assign last       = data_reg.last;

endmodule

`default_nettype wire

// ===== rtl/pvca_ctrl.sv =====
// Request sequencer: busy flags, table scan over the memory and result issue.
`timescale 1ns / 1ps
`default_nettype none
`include "priority_voice_channel_allocator_core_assert.svh"

module pvca_ctrl #(
    parameter int MAX_CHANNELS = 8,
    parameter int ORIGIN_BITS  = 16,
    parameter int IDX_W        = 3,
    parameter int CNT_W        = 4,
    parameter int ENTRY_W      = 33
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         func,
    input  wire logic [15:0]        origin_id,
    input  wire logic [7:0]         sound_id,
    input  wire logic [7:0]         sound_priority,
    input  wire logic               pickup_flag,
    input  wire logic [2:0]         channel_index,
    input  wire logic [CNT_W-1:0]   cfg_count,
    input  wire logic               cfg_enable,
    output logic                    mem_rd_en,
    output logic [IDX_W-1:0]        mem_rd_addr,
    input  wire logic [ENTRY_W-1:0] mem_rd_data,
    output logic                    mem_wr_en,
    output logic [IDX_W-1:0]        mem_wr_addr,
    output logic [ENTRY_W-1:0]      mem_wr_data,
    input  wire logic               res_ready,
    output logic                    res_push,
    output pvca_pkg::res_t          res
);
    import pvca_pkg::*;

    // Bit positions of one table entry.
    localparam int PICK_POS = ORIGIN_BITS;
    localparam int PRI_LO   = ORIGIN_BITS + 1;
    localparam int PRI_HI   = ORIGIN_BITS + PRI_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_EMIT_STOP,
        ST_EMIT_GRANT,
        ST_EMIT_ONE
    } state_t;

    state_t                  state_reg,       state_next;
    logic [MAX_CHANNELS-1:0] busy_reg,        busy_next;
    func_t                   func_reg,        func_next;
    logic [ORIGIN_BITS-1:0]  org_reg,         org_next;
    logic [SOUND_W-1:0]      snd_reg,         snd_next;
    logic [PRI_W-1:0]        pri_reg,         pri_next;
    logic                    pick_reg,        pick_next;
    logic [CNT_W-1:0]        issue_cnt_reg,   issue_cnt_next;
    logic                    pend_reg,        pend_next;
    logic                    pend_last_reg,   pend_last_next;
    logic [IDX_W-1:0]        pend_idx_reg,    pend_idx_next;
    logic                    match_found_reg, match_found_next;
    logic [IDX_W-1:0]        match_idx_reg,   match_idx_next;
    logic                    free_found_reg,  free_found_next;
    logic [IDX_W-1:0]        free_idx_reg,    free_idx_next;
    logic                    steal_found_reg, steal_found_next;
    logic [IDX_W-1:0]        steal_idx_reg,   steal_idx_next;
    logic [IDX_W-1:0]        chan_reg,        chan_next;
    logic [IDX_W-1:0]        grant_idx_reg,   grant_idx_next;
    kind_t                   kind_reg,        kind_next;

    logic [ORIGIN_BITS-1:0]  e_origin;
    logic                    e_pick;
    logic [PRI_W-1:0]        e_pri;
    logic                    e_busy;
    logic                    org_hit;
    logic                    sel_hit;
    logic [IDX_W-1:0]        rel_idx;
    logic                    rel_ok;
    logic                    grant_fire;
    logic                    clear_fire;

    // Fields of the entry read in the previous cycle.
    assign e_origin = mem_rd_data[ORIGIN_BITS-1:0];
    assign e_pick   = mem_rd_data[PICK_POS];
    assign e_pri    = mem_rd_data[PRI_HI:PRI_LO];
    assign e_busy   = busy_reg[pend_idx_reg];
    assign org_hit  = e_busy && (e_origin == org_reg);
    assign sel_hit  = (func_reg == FUNC_STOP) ? org_hit : (org_hit && (e_pick == pick_reg));

    // Release is valid only for a busy channel inside the working count.
    assign rel_idx = IDX_W'(channel_index);
    assign rel_ok  = (32'(channel_index) < 32'(cfg_count)) && busy_reg[rel_idx];

    assign grant_fire = (state_reg == ST_EMIT_GRANT) && res_ready;
    assign clear_fire = (state_reg == ST_IDLE) && in_valid
                        && (func_t'(func) == FUNC_CLEAR) && cfg_enable;

    // Next-state and datapath logic.
    always_comb
    begin
        state_next       = state_reg;
        busy_next        = busy_reg;
        func_next        = func_reg;
        org_next         = org_reg;
        snd_next         = snd_reg;
        pri_next         = pri_reg;
        pick_next        = pick_reg;
        issue_cnt_next   = issue_cnt_reg;
        pend_next        = 1'b0;
        pend_last_next   = 1'b0;
        pend_idx_next    = pend_idx_reg;
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        steal_found_next = steal_found_reg;
        steal_idx_next   = steal_idx_reg;
        chan_next        = chan_reg;
        grant_idx_next   = grant_idx_reg;
        kind_next        = kind_reg;
        in_stall         = (state_reg != ST_IDLE);
        mem_rd_en        = 1'b0;
        mem_rd_addr      = issue_cnt_reg[IDX_W-1:0];
        mem_wr_en        = 1'b0;
        mem_wr_addr      = grant_idx_reg;
        mem_wr_data      = {snd_reg, pri_reg, pick_reg, org_reg};
        res_push         = 1'b0;
        res.kind         = kind_reg;
        res.channel      = CHAN_W'(chan_reg);
        res.last         = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    // Take the item and clear the scan bookkeeping.
                    func_next        = func_t'(func);
                    org_next         = ORIGIN_BITS'(origin_id);
                    snd_next         = sound_id;
                    pri_next         = sound_priority;
                    pick_next        = pickup_flag;
                    issue_cnt_next   = '0;
                    match_found_next = 1'b0;
                    free_found_next  = 1'b0;
                    steal_found_next = 1'b0;
                    chan_next        = '0;
                    kind_next        = KIND_NONE;
                    case (func_t'(func))
                        FUNC_START, FUNC_STOP:
                        begin
                            if (!cfg_enable)
                            begin
                                kind_next  = (func_t'(func) == FUNC_START) ? KIND_REFUSED
                                                                           : KIND_NONE;
                                state_next = ST_EMIT_ONE;
                            end
                            else if (cfg_count == '0)
                            begin
                                state_next = ST_DECIDE;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        FUNC_RELEASE:
                        begin
                            if (cfg_enable && rel_ok)
                            begin
                                busy_next[rel_idx] = 1'b0;
                                kind_next          = KIND_STOPPED;
                                chan_next          = rel_idx;
                            end
                            state_next = ST_EMIT_ONE;
                        end
                        FUNC_CLEAR:
                        begin
                            if (clear_fire)
                            begin
                                kind_next = (|busy_reg) ? KIND_STOPPED : KIND_NONE;
                                busy_next = '0;
                            end
                            state_next = ST_EMIT_ONE;
                        end
                        default:
                        begin
                            state_next = ST_EMIT_ONE;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // Issue one read per cycle over the working channels.
                mem_rd_en = (issue_cnt_reg < cfg_count);
                if (mem_rd_en)
                begin
                    issue_cnt_next = issue_cnt_reg + CNT_W'(1);
                    pend_next      = 1'b1;
                    pend_last_next = ((issue_cnt_reg + CNT_W'(1)) == cfg_count);
                    pend_idx_next  = issue_cnt_reg[IDX_W-1:0];
                end
                // Check the entry that came back from the previous read.
                if (pend_reg)
                begin
                    if (!match_found_reg && sel_hit)
                    begin
                        match_found_next = 1'b1;
                        match_idx_next   = pend_idx_reg;
                    end
                    if (!free_found_reg && !e_busy)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = pend_idx_reg;
                    end
                    if (!steal_found_reg && e_busy && (e_pri >= pri_reg))
                    begin
                        steal_found_next = 1'b1;
                        steal_idx_next   = pend_idx_reg;
                    end
                    if (pend_last_reg)
                    begin
                        state_next = ST_DECIDE;
                    end
                end
            end

            ST_DECIDE:
            begin
                if (func_reg == FUNC_STOP)
                begin
                    if (match_found_reg)
                    begin
                        busy_next[match_idx_reg] = 1'b0;
                        kind_next                = KIND_STOPPED;
                        chan_next                = match_idx_reg;
                    end
                    state_next = ST_EMIT_ONE;
                end
                else if (match_found_reg)
                begin
                    // Stop the older sound, then take the lowest free channel.
                    busy_next[match_idx_reg] = 1'b0;
                    chan_next                = match_idx_reg;
                    grant_idx_next = (free_found_reg && (free_idx_reg < match_idx_reg))
                                     ? free_idx_reg : match_idx_reg;
                    state_next     = ST_EMIT_STOP;
                end
                else if (free_found_reg)
                begin
                    grant_idx_next = free_idx_reg;
                    state_next     = ST_EMIT_GRANT;
                end
                else if (steal_found_reg)
                begin
                    // Table full: take over a channel of equal or lower importance.
                    busy_next[steal_idx_reg] = 1'b0;
                    chan_next                = steal_idx_reg;
                    grant_idx_next           = steal_idx_reg;
                    state_next               = ST_EMIT_STOP;
                end
                else
                begin
                    kind_next  = KIND_REFUSED;
                    state_next = ST_EMIT_ONE;
                end
            end

            ST_EMIT_STOP:
            begin
                res.kind = KIND_STOPPED;
                res.last = 1'b0;
                if (res_ready)
                begin
                    res_push   = 1'b1;
                    state_next = ST_EMIT_GRANT;
                end
            end

            ST_EMIT_GRANT:
            begin
                res.kind    = KIND_GRANTED;
                res.channel = CHAN_W'(grant_idx_reg);
                if (grant_fire)
                begin
                    res_push                 = 1'b1;
                    mem_wr_en                = 1'b1;
                    busy_next[grant_idx_reg] = 1'b1;
                    state_next               = ST_IDLE;
                end
            end

            ST_EMIT_ONE:
            begin
                if (res_ready)
                begin
                    res_push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            busy_reg        <= '0;
            func_reg        <= FUNC_START;
            org_reg         <= '0;
            snd_reg         <= '0;
            pri_reg         <= '0;
            pick_reg        <= 1'b0;
            issue_cnt_reg   <= '0;
            pend_reg        <= 1'b0;
            pend_last_reg   <= 1'b0;
            pend_idx_reg    <= '0;
            match_found_reg <= 1'b0;
            match_idx_reg   <= '0;
            free_found_reg  <= 1'b0;
            free_idx_reg    <= '0;
            steal_found_reg <= 1'b0;
            steal_idx_reg   <= '0;
            chan_reg        <= '0;
            grant_idx_reg   <= '0;
            kind_reg        <= KIND_NONE;
        end
        else
        begin
            state_reg       <= state_next;
            busy_reg        <= busy_next;
            func_reg        <= func_next;
            org_reg         <= org_next;
            snd_reg         <= snd_next;
            pri_reg         <= pri_next;
            pick_reg        <= pick_next;
            issue_cnt_reg   <= issue_cnt_next;
            pend_reg        <= pend_next;
            pend_last_reg   <= pend_last_next;
            pend_idx_reg    <= pend_idx_next;
            match_found_reg <= match_found_next;
            match_idx_reg   <= match_idx_next;
            free_found_reg  <= free_found_next;
            free_idx_reg    <= free_idx_next;
            steal_found_reg <= steal_found_next;
            steal_idx_reg   <= steal_idx_next;
            chan_reg        <= chan_next;
            grant_idx_reg   <= grant_idx_next;
            kind_reg        <= kind_next;
        end
    end

    // A channel is never granted while it still holds a sound.
    `PVCA_ASSERT_IMP(a_grant_is_free, state_reg == ST_EMIT_GRANT, !busy_reg[grant_idx_reg], "granted channel is busy")
    // A completed grant marks its channel busy.
    `PVCA_ASSERT_NEXT(a_grant_sets_busy, grant_fire, busy_reg[$past(grant_idx_reg)], "grant did not set busy")
    // A clear leaves the whole table free.
    `PVCA_ASSERT_NEXT(a_clear_empties, clear_fire, busy_reg == '0, "clear left a busy channel")
    // The scan never reads past the working count.
    `PVCA_ASSERT_IMP(a_scan_in_range, mem_rd_en, 32'(mem_rd_addr) < 32'(cfg_count), "scan read beyond count")

endmodule

`default_nettype wire

// ===== rtl/priority_voice_channel_allocator_core.sv =====
// Top level of the priority voice channel allocator.
//
// Requests enter on the input channel (in_valid / in_stall); each request gives one
// or two result items on the output channel (out_valid / out_stall), the final one
// marked by last. A start or stop-by-origin request reads the channel table memory
// once per channel in use, one entry per cycle over its single read port, in ST_SCAN.
// The channels in use are channels_in_use capped at MAX_CHANNELS. ST_DECIDE then
// picks the result, which ST_EMIT_ONE, or ST_EMIT_STOP and then ST_EMIT_GRANT, push
// into the output register. With zero channels in use the scan is skipped and the
// request goes to ST_DECIDE. Release, clear and disabled requests need no table read;
// their result goes out from ST_EMIT_ONE. The next item is accepted in the cycle after
// the last result of the current one has entered the output register, so the sequencer
// takes no new item before it is through with the current one. If the receiver stalls,
// the result stays in the output register and the sequencer waits with its next result;
// in_stall stays high until the last result of the item has entered the output register.
// Reset frees every channel, sets channels_in_use to 8 and enables sound; the table
// memory needs no clearing because only busy entries are ever compared. Configuration
// goes through the APB-style port: channels_in_use at 0x0, sfx_enable at 0x4; writes
// are expected only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module priority_voice_channel_allocator_core #(
    parameter int MAX_CHANNELS = 8,
    parameter int ORIGIN_BITS  = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [pvca_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [pvca_pkg::PDATA_W-1:0]  pwdata,
    output logic      [pvca_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [1:0]                    func,
    input  wire logic [15:0]                   origin_id,
    input  wire logic [7:0]                    sound_id,
    input  wire logic [7:0]                    sound_priority,
    input  wire logic                          pickup_flag,
    input  wire logic [2:0]                    channel_index,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [1:0]                         event_kind,
    output logic [2:0]                         channel,
    output logic                               last
);
    import pvca_pkg::*;

    localparam int IDX_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CNT_W   = $clog2(MAX_CHANNELS + 1);
    localparam int ENTRY_W = SOUND_W + PRI_W + 1 + ORIGIN_BITS;

    logic [CFG_CNT_W-1:0] cfg_count_reg;
    logic [CFG_CNT_W-1:0] cfg_count_next;
    logic                 cfg_enable_reg;
    logic                 cfg_enable_next;
    logic [CNT_W-1:0]     n_eff;
    logic                 cfg_write;

    logic                 mem_rd_en;
    logic [IDX_W-1:0]     mem_rd_addr;
    logic [ENTRY_W-1:0]   mem_rd_data;
    logic                 mem_wr_en;
    logic [IDX_W-1:0]     mem_wr_addr;
    logic [ENTRY_W-1:0]   mem_wr_data;
    logic                 res_ready;
    logic                 res_push;
    res_t                 res;

    // Register port: writes complete in the access cycle, reads return the value.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_count_next  = cfg_count_reg;
        cfg_enable_next = cfg_enable_reg;
        if (cfg_write)
        begin
            case (paddr[2])
                REG_IDX_CHANNELS: cfg_count_next  = pwdata[CFG_CNT_W-1:0];
                REG_IDX_ENABLE:   cfg_enable_next = pwdata[0];
                default:          cfg_count_next  = cfg_count_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_IDX_CHANNELS: prdata = PDATA_W'(cfg_count_reg);
            REG_IDX_ENABLE:   prdata = PDATA_W'(cfg_enable_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_count_reg  <= CFG_CNT_W'(8);
            cfg_enable_reg <= 1'b1;
        end
        else
        begin
            cfg_count_reg  <= cfg_count_next;
            cfg_enable_reg <= cfg_enable_next;
        end
    end

    // Working channel count, capped at the table size.
    always_comb
    begin
        if (32'(cfg_count_reg) > MAX_CHANNELS)
        begin
            n_eff = CNT_W'(MAX_CHANNELS);
        end
        else
        begin
            n_eff = CNT_W'(cfg_count_reg);
        end
    end

    pvca_ctrl #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .ORIGIN_BITS  (ORIGIN_BITS),
        .IDX_W        (IDX_W),
        .CNT_W        (CNT_W),
        .ENTRY_W      (ENTRY_W)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .origin_id      (origin_id),
        .sound_id       (sound_id),
        .sound_priority (sound_priority),
        .pickup_flag    (pickup_flag),
        .channel_index  (channel_index),
        .cfg_count      (n_eff),
        .cfg_enable     (cfg_enable_reg),
        .mem_rd_en      (mem_rd_en),
        .mem_rd_addr    (mem_rd_addr),
        .mem_rd_data    (mem_rd_data),
        .mem_wr_en      (mem_wr_en),
        .mem_wr_addr    (mem_wr_addr),
        .mem_wr_data    (mem_wr_data),
        .res_ready      (res_ready),
        .res_push       (res_push),
        .res            (res)
    );

    pvca_chan_mem #(
        .DEPTH  (MAX_CHANNELS),
        .ADDR_W (IDX_W),
        .DATA_W (ENTRY_W)
    ) u_chan_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    pvca_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .res_push   (res_push),
        .res        (res),
        .res_ready  (res_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .event_kind (event_kind),
        .channel    (channel),
        .last       (last)
    );

endmodule

`default_nettype wire

// ===== tb/priority_voice_channel_allocator_core_test.sv =====
// Self-checking testbench of the priority voice channel allocator core.
`timescale 1ns / 1ps

module priority_voice_channel_allocator_core_test;

    import pvca_pkg::*;

    localparam int VOICES      = 8;
    localparam int SETTLE      = 20;
    localparam int HOLD_CYCLES = 80;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                in_valid;
    logic                in_stall;
    logic [1:0]          func;
    logic [15:0]         origin_id;
    logic [7:0]          sound_id;
    logic [7:0]          sound_priority;
    logic                pickup_flag;
    logic [2:0]          channel_index;
    logic                out_valid;
    logic                out_stall;
    logic [1:0]          event_kind;
    logic [2:0]          channel;
    logic                last;

    // Local copy of the channel table and of the registers.
    logic        voice_busy     [VOICES];
    logic [7:0]  voice_sound    [VOICES];
    logic [7:0]  voice_priority [VOICES];
    logic [15:0] voice_origin   [VOICES];
    logic        voice_pickup   [VOICES];
    logic [3:0]  cfg_channels;
    logic        cfg_enable;

    // Results still owed by the block, oldest first.
    res_t        pending_events[$];

    logic [15:0] origin_pool[6];
    bit          idle_on;
    bit          hold_request;
    int          mismatches;
    int          requests_sent;
    int          events_checked;
    int          grants_seen;
    int          stops_seen;
    int          refusals_seen;
    int          input_stall_cycles;

    priority_voice_channel_allocator_core #(
        .MAX_CHANNELS (VOICES),
        .ORIGIN_BITS  (16)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .origin_id      (origin_id),
        .sound_id       (sound_id),
        .sound_priority (sound_priority),
        .pickup_flag    (pickup_flag),
        .channel_index  (channel_index),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .event_kind     (event_kind),
        .channel        (channel),
        .last           (last)
    );

    // Free-running clock with a 2 ns period.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Generous overall limit in case the block hangs.
    initial
    begin
        #1_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // Receiver stall: short random bursts, plus one long hold when requested.
    initial
    begin : receiver_stall
        int burst;
        int hold_left;
        burst = 0;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall = 1'b1;
                hold_left--;
            end
            else if (burst > 0)
            begin
                out_stall = 1'b1;
                burst--;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_stall = 1'b1;
                burst = $urandom_range(1, 4) - 1;
            end
            else
            begin
                out_stall = 1'b0;
            end
        end
    end

    // Compare each handed-over result with the oldest one owed.
    always @(posedge clk)
    begin : result_check
        res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            events_checked++;
            case (kind_t'(event_kind))
                KIND_GRANTED: grants_seen++;
                KIND_STOPPED: stops_seen++;
                KIND_REFUSED: refusals_seen++;
                default: ;
            endcase
            if (pending_events.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: kind %0d channel %0d last %0b",
                             event_kind, channel, last);
            end
            else
            begin
                want = pending_events.pop_front();
                if (event_kind !== want.kind || channel !== want.channel
                    || last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result mismatch: expected kind %0d channel %0d ",
                                  "last %0b, got kind %0d channel %0d last %0b"},
                                 want.kind, want.channel, want.last,
                                 event_kind, channel, last);
                end
            end
        end
    end

    function automatic void queue_event(kind_t k, int ch, bit is_last);
        res_t ev;
        ev.kind = k;
        ev.channel = ch[2:0];
        ev.last = is_last;
        pending_events.push_back(ev);
    endfunction

    // Work out the results of one request and update the local table.
    function automatic void predict_voice_request(func_t f, logic [15:0] org,
            logic [7:0] snd, logic [7:0] pri, logic pick, logic [2:0] idx);
        int n;
        int c;
        bit any;
        n = (cfg_channels > VOICES) ? VOICES : int'(cfg_channels);
        if (f == FUNC_START)
        begin
            if (!cfg_enable)
            begin
                queue_event(KIND_REFUSED, 0, 1'b1);
                return;
            end
            // An older sound of the same origin and pickup kind is stopped first.
            for (c = 0; c < n; c++)
            begin
                if (voice_busy[c] && voice_origin[c] == org && voice_pickup[c] == pick)
                begin
                    voice_busy[c] = 1'b0;
                    queue_event(KIND_STOPPED, c, 1'b0);
                    break;
                end
            end
            // Reuse a matching channel in the busy prefix, or take the first free one.
            for (c = 0; c < n && voice_busy[c]; c++)
            begin
                if (org != 0 && voice_origin[c] == org && voice_pickup[c] == pick)
                begin
                    voice_busy[c] = 1'b0;
                    queue_event(KIND_STOPPED, c, 1'b0);
                    break;
                end
            end
            // Table full: steal the first channel of equal or lower importance.
            if (c >= n)
            begin
                for (c = 0; c < n; c++)
                    if (voice_priority[c] >= pri)
                        break;
                if (c >= n)
                begin
                    queue_event(KIND_REFUSED, 0, 1'b1);
                    return;
                end
                voice_busy[c] = 1'b0;
                queue_event(KIND_STOPPED, c, 1'b0);
            end
            voice_busy[c] = 1'b1;
            voice_sound[c] = snd;
            voice_priority[c] = pri;
            voice_origin[c] = org;
            voice_pickup[c] = pick;
            queue_event(KIND_GRANTED, c, 1'b1);
            return;
        end
        if (!cfg_enable)
        begin
            queue_event(KIND_NONE, 0, 1'b1);
            return;
        end
        case (f)
            FUNC_STOP:
            begin
                for (c = 0; c < n; c++)
                begin
                    if (voice_busy[c] && voice_origin[c] == org)
                    begin
                        voice_busy[c] = 1'b0;
                        queue_event(KIND_STOPPED, c, 1'b1);
                        return;
                    end
                end
                queue_event(KIND_NONE, 0, 1'b1);
            end
            FUNC_RELEASE:
            begin
                if (int'(idx) < n && voice_busy[idx])
                begin
                    voice_busy[idx] = 1'b0;
                    queue_event(KIND_STOPPED, int'(idx), 1'b1);
                end
                else
                begin
                    queue_event(KIND_NONE, 0, 1'b1);
                end
            end
            default:
            begin
                // Clear frees the whole table, also entries beyond the count in use.
                any = 1'b0;
                for (c = 0; c < VOICES; c++)
                begin
                    if (voice_busy[c])
                        any = 1'b1;
                    voice_busy[c] = 1'b0;
                end
                queue_event(any ? KIND_STOPPED : KIND_NONE, 0, 1'b1);
            end
        endcase
    endfunction

    // Offer one item; valid is left high so that the next item may follow directly.
    task automatic send_request(input func_t f, input logic [15:0] org,
            input logic [7:0] snd, input logic [7:0] pri, input logic pick,
            input logic [2:0] idx);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 4);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        func = f;
        origin_id = org;
        sound_id = snd;
        sound_priority = pri;
        pickup_flag = pick;
        channel_index = idx;
        do
        begin
            @(posedge clk);
            if (in_stall)
                input_stall_cycles++;
        end
        while (in_stall);
        requests_sent++;
        predict_voice_request(f, org, snd, pri, pick, idx);
    endtask

    // Stop offering items and wait until every owed result has come back.
    task automatic wait_for_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Register write followed by a read-back of the same register.
    task automatic write_register(input logic [0:0] reg_idx, input logic [31:0] value);
        logic [31:0] got;
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {reg_idx, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        penable = 1'b0;
        pwrite = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        got = prdata;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        if (reg_idx == REG_IDX_CHANNELS)
        begin
            cfg_channels = value[3:0];
            if (got[3:0] !== value[3:0])
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("channel count read-back: expected %0d, got %0d",
                             value[3:0], got[3:0]);
            end
        end
        else
        begin
            cfg_enable = value[0];
            if (got[0] !== value[0])
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("sound enable read-back: expected %0b, got %0b",
                             value[0], got[0]);
            end
        end
    endtask

    function automatic func_t pick_request();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return FUNC_START;
        else if (r < 75)
            return FUNC_STOP;
        else if (r < 94)
            return FUNC_RELEASE;
        return FUNC_CLEAR;
    endfunction

    // Mostly requests from a small set of emitters so that origins collide;
    // the rest is noise with arbitrary origins and codes.
    task automatic send_random_request();
        func_t       f;
        logic [15:0] org;
        if ($urandom_range(0, 99) < 85)
        begin
            f = pick_request();
            org = origin_pool[$urandom_range(0, 5)];
        end
        else
        begin
            f = func_t'($urandom_range(0, 3));
            org = 16'($urandom_range(0, 65535));
        end
        send_request(f, org, 8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
    endtask

    // Fixed sequence covering the table filling, reuse, stealing and refusal.
    task automatic test_directed_requests();
        send_request(FUNC_CLEAR,   16'h0000, 8'd1,   8'd0,   1'b0, 3'd0);
        send_request(FUNC_STOP,    16'h0000, 8'd1,   8'd0,   1'b0, 3'd0);
        send_request(FUNC_RELEASE, 16'h0000, 8'd1,   8'd0,   1'b0, 3'd0);
        send_request(FUNC_START,   16'h0000, 8'd1,   8'd0,   1'b0, 3'd0);
        // Same null origin again: the old sound is stopped and its channel reused.
        send_request(FUNC_START,   16'h0000, 8'd2,   8'd0,   1'b0, 3'd0);
        send_request(FUNC_START,   16'hFFFF, 8'd255, 8'd255, 1'b1, 3'd7);
        send_request(FUNC_START,   16'hFFFF, 8'h80,  8'h80,  1'b0, 3'd0);
        send_request(FUNC_START,   16'hFFFF, 8'h7F,  8'h7F,  1'b1, 3'd0);
        send_request(FUNC_START,   16'h1234, 8'd10,  8'd10,  1'b0, 3'd0);
        send_request(FUNC_START,   16'h0002, 8'd20,  8'd200, 1'b0, 3'd0);
        send_request(FUNC_START,   16'h0003, 8'd21,  8'd200, 1'b1, 3'd0);
        send_request(FUNC_START,   16'h0004, 8'd22,  8'd200, 1'b0, 3'd0);
        send_request(FUNC_START,   16'h0005, 8'd23,  8'd200, 1'b1, 3'd0);
        // Full table: nothing is as important, then two steals.
        send_request(FUNC_START,   16'h0777, 8'd30,  8'd255, 1'b0, 3'd0);
        send_request(FUNC_START,   16'h0778, 8'd31,  8'd150, 1'b0, 3'd0);
        send_request(FUNC_START,   16'h0779, 8'd32,  8'd0,   1'b1, 3'd0);
        send_request(FUNC_STOP,    16'hFFFF, 8'd1,   8'd0,   1'b0, 3'd0);
        send_request(FUNC_STOP,    16'hABCD, 8'd1,   8'd0,   1'b1, 3'd0);
        send_request(FUNC_RELEASE, 16'h0000, 8'd1,   8'd0,   1'b0, 3'd7);
        send_request(FUNC_RELEASE, 16'h0000, 8'd1,   8'd0,   1'b0, 3'd7);
        send_request(FUNC_CLEAR,   16'h0000, 8'd1,   8'd0,   1'b0, 3'd0);
        send_request(FUNC_START,   16'h5555, 8'hAA,  8'h55,  1'b1, 3'd5);
        wait_for_results();
    endtask

    // Sound disabled, zero channels and a count above the table size.
    task automatic test_register_settings();
        write_register(REG_IDX_ENABLE, 32'd0);
        send_request(FUNC_START,   16'h5555, 8'd9, 8'd9, 1'b1, 3'd0);
        send_request(FUNC_STOP,    16'h5555, 8'd9, 8'd9, 1'b1, 3'd0);
        send_request(FUNC_RELEASE, 16'h0000, 8'd9, 8'd9, 1'b0, 3'd0);
        send_request(FUNC_CLEAR,   16'h0000, 8'd9, 8'd9, 1'b0, 3'd0);
        wait_for_results();
        write_register(REG_IDX_ENABLE, 32'd1);
        write_register(REG_IDX_CHANNELS, 32'd0);
        send_request(FUNC_START,   16'h0042, 8'd9, 8'd255, 1'b0, 3'd0);
        send_request(FUNC_STOP,    16'h5555, 8'd9, 8'd9,   1'b1, 3'd0);
        send_request(FUNC_RELEASE, 16'h0000, 8'd9, 8'd9,   1'b0, 3'd0);
        send_request(FUNC_CLEAR,   16'h0000, 8'd9, 8'd9,   1'b0, 3'd0);
        wait_for_results();
        write_register(REG_IDX_CHANNELS, 32'd15);
        send_request(FUNC_START,   16'h0042, 8'd9, 8'd1, 1'b0, 3'd0);
        wait_for_results();
        write_register(REG_IDX_CHANNELS, 32'd1);
        send_request(FUNC_START,   16'h0043, 8'd9, 8'd1, 1'b0, 3'd0);
        send_request(FUNC_START,   16'h0044, 8'd9, 8'd0, 1'b1, 3'd0);
        wait_for_results();
    endtask

    // One setting of the registers followed by a stream of random requests.
    task automatic test_random_phase(input logic [3:0] chans, input logic en,
            input int count);
        wait_for_results();
        write_register(REG_IDX_CHANNELS, {28'd0, chans});
        write_register(REG_IDX_ENABLE, {31'd0, en});
        repeat (count) send_random_request();
        wait_for_results();
    endtask

    // The receiver holds off for a long stretch while items keep coming.
    task automatic test_output_backpressure();
        wait_for_results();
        write_register(REG_IDX_CHANNELS, 32'd8);
        write_register(REG_IDX_ENABLE, 32'd1);
        hold_request = 1'b1;
        repeat (30) send_random_request();
        wait_for_results();
    endtask

    // Back-to-back traffic with no idling on either side.
    task automatic test_full_rate_stream();
        wait_for_results();
        write_register(REG_IDX_CHANNELS, 32'd4);
        idle_on = 1'b0;
        repeat (70) send_random_request();
        wait_for_results();
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        func = FUNC_START;
        origin_id = '0;
        sound_id = 8'd1;
        sound_priority = '0;
        pickup_flag = 1'b0;
        channel_index = '0;
        hold_request = 1'b0;
        idle_on = 1'b1;
        mismatches = 0;
        requests_sent = 0;
        events_checked = 0;
        grants_seen = 0;
        stops_seen = 0;
        refusals_seen = 0;
        input_stall_cycles = 0;
        cfg_channels = 4'd8;
        cfg_enable = 1'b1;
        for (int i = 0; i < VOICES; i++)
        begin
            voice_busy[i] = 1'b0;
            voice_sound[i] = '0;
            voice_priority[i] = '0;
            voice_origin[i] = '0;
            voice_pickup[i] = 1'b0;
        end
        origin_pool[0] = 16'h0000;
        origin_pool[1] = 16'hFFFF;
        origin_pool[2] = 16'h0001;
        origin_pool[3] = 16'h8000;
        origin_pool[4] = 16'($urandom_range(2, 65534));
        origin_pool[5] = 16'($urandom_range(2, 65534));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_requests();
        test_register_settings();
        test_random_phase(4'd8, 1'b1, 90);
        test_random_phase(4'd3, 1'b1, 70);
        test_random_phase(4'd1, 1'b1, 50);
        test_random_phase(4'd15, 1'b1, 70);
        test_random_phase(4'd5, 1'b0, 20);
        test_random_phase(4'd6, 1'b1, 70);
        test_output_backpressure();
        test_full_rate_stream();

        $display("covered %0d requests and %0d results: %0d grants, %0d stops, %0d refusals",
                 requests_sent, events_checked, grants_seen, stops_seen, refusals_seen);
        $display("zero to fifteen channels, sound off and on; %0d cycles of input stall seen",
                 input_stall_cycles);
        if (mismatches == 0 && pending_events.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
